FILE: src/bmcs_pkg.sv
// Package for the background-mode contrast stretch block.
// Holds widths, bin limits, state enums and the divider request/response structs.
// No dependencies.
package bmcs_pkg;

  localparam int unsigned PIX_W  = 8;
  localparam int unsigned BIN_W  = 17;
  localparam int unsigned NUM_BINS = 256;

  // Saturation value of a histogram bin
  localparam logic [BIN_W-1:0] BIN_MAX = '1;
  // Full-scale output code
  localparam logic [PIX_W-1:0] FULL_SCALE = 8'd255;

  // Input command codes
  localparam logic CMD_COUNT = 1'b0;
  localparam logic CMD_MAP   = 1'b1;

  // Top-level sequencer
  typedef enum logic [2:0] {
    ST_RUN,
    ST_DIV,
    ST_WAIT,
    ST_SCAN,
    ST_FIN
  } top_state_e;

  // Divider phases
  typedef enum logic [1:0] {
    D_IDLE,
    D_PREP,
    D_ITER,
    D_DONE
  } div_state_e;

  typedef struct packed {
    logic             start;
    logic [PIX_W-1:0] pixel;
    logic [PIX_W-1:0] bg;
    logic [PIX_W-1:0] peak;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [PIX_W-1:0] quot;
  } div_rsp_t;

endpackage

FILE: src/bmcs_in_if.sv
// Input channel of the contrast stretch block: valid/ready plus pixel command fields.
// Depends on nothing.
interface bmcs_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] pixel;
  logic       last;

  modport source (output valid, cmd, pixel, last, input ready);
  modport sink   (input valid, cmd, pixel, last, output ready);
endinterface

FILE: src/bmcs_out_if.sv
// Output channel of the contrast stretch block: valid/ready plus stretched pixel.
// Depends on nothing.
interface bmcs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] stretched;

  modport source (output valid, stretched, input ready);
  modport sink   (input valid, stretched, output ready);
endinterface

FILE: src/bmcs_hist.sv
// Histogram store: 256 x 17-bit synchronous RAM, one read and one write port.
// Per-entry valid bits give the all-zero reset and the bulk clear. Uses bmcs_pkg.
module bmcs_hist (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [bmcs_pkg::PIX_W-1:0]  rd_addr_i,
  input  logic                        wr_en_i,
  input  logic [bmcs_pkg::PIX_W-1:0]  wr_addr_i,
  input  logic [bmcs_pkg::BIN_W-1:0]  wr_data_i,
  input  logic                        clr_i,
  output logic [bmcs_pkg::BIN_W-1:0]  rd_data_o
);

  logic [bmcs_pkg::BIN_W-1:0]    mem_q [bmcs_pkg::NUM_BINS];
  logic [bmcs_pkg::BIN_W-1:0]    rd_data_q;
  logic [bmcs_pkg::NUM_BINS-1:0] vld_q;
  logic                          rd_vld_q;

  // RAM array, read-first, registered read
  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[rd_addr_i];
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Entry valid bits; an invalid entry reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= vld_q[rd_addr_i];
      if (clr_i) begin
        vld_q <= '0;
      end else if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_data_q : '0;

endmodule

FILE: src/bmcs_div.sv
// Stretch divider: floor((pixel-bg)*255/(peak-bg)), clamped to 255, one quotient bit a cycle.
// Request/response structs from bmcs_pkg.
module bmcs_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bmcs_pkg::div_req_t  req_i,
  input  logic                ack_i,
  output bmcs_pkg::div_rsp_t  rsp_o
);

  bmcs_pkg::div_state_e state_q, state_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [7:0]  diff_q, diff_d;
  logic [7:0]  den_q, den_d;
  logic        zero_q, zero_d;
  logic [7:0]  rem_q, rem_d;
  logic [7:0]  nlo_q, nlo_d;
  logic [7:0]  quot_q, quot_d;
  logic [15:0] num;
  logic [8:0]  trial;
  logic [8:0]  sub;
  logic        ge;

  // diff*255 as a shift and subtract
  assign num   = {diff_q, 8'd0} - {8'd0, diff_q};
  assign trial = {rem_q, nlo_q[7]};
  assign sub   = trial - {1'b0, den_q};
  assign ge    = (trial >= {1'b0, den_q});

  // Phase sequencing and datapath
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    diff_d  = diff_q;
    den_d   = den_q;
    zero_d  = zero_q;
    rem_d   = rem_q;
    nlo_d   = nlo_q;
    quot_d  = quot_q;
    unique case (state_q)
      bmcs_pkg::D_IDLE: begin
        if (req_i.start) begin
          diff_d  = req_i.pixel - req_i.bg;
          den_d   = req_i.peak - req_i.bg;
          zero_d  = (req_i.pixel < req_i.bg) || (req_i.peak <= req_i.bg);
          state_d = bmcs_pkg::D_PREP;
        end
      end
      bmcs_pkg::D_PREP: begin
        rem_d  = num[15:8];
        nlo_d  = num[7:0];
        quot_d = '0;
        cnt_d  = '0;
        if (zero_q) begin
          state_d = bmcs_pkg::D_DONE;
        end else if (num[15:8] >= den_q) begin
          // quotient would need a ninth bit
          quot_d  = bmcs_pkg::FULL_SCALE;
          state_d = bmcs_pkg::D_DONE;
        end else begin
          state_d = bmcs_pkg::D_ITER;
        end
      end
      bmcs_pkg::D_ITER: begin
        rem_d  = ge ? sub[7:0] : trial[7:0];
        nlo_d  = {nlo_q[6:0], 1'b0};
        quot_d = {quot_q[6:0], ge};
        cnt_d  = cnt_q + 3'd1;
        if (cnt_q == 3'd7) begin
          state_d = bmcs_pkg::D_DONE;
        end
      end
      bmcs_pkg::D_DONE: begin
        if (ack_i) begin
          state_d = bmcs_pkg::D_IDLE;
        end
      end
      default: state_d = bmcs_pkg::D_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bmcs_pkg::D_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    diff_q <= diff_d;
    den_q  <= den_d;
    zero_q <= zero_d;
    rem_q  <= rem_d;
    nlo_q  <= nlo_d;
    quot_q <= quot_d;
  end

  assign rsp_o.done = (state_q == bmcs_pkg::D_DONE);
  assign rsp_o.quot = quot_q;

endmodule

FILE: src/background_mode_contrast_stretch_top.sv
// Background-mode contrast stretch, top level.
// Channels: pix_in_i carries {cmd, pixel, last}; pix_out_o carries stretched.
// An item is accepted when valid and ready are both high.
//   cmd 0 (counting): the pixel's bin is incremented, saturating at 17 bits.
//     One counting transaction per cycle while ready is high; the bin
//     RAM read-modify-write forwards between back-to-back hits. No result.
//   cmd 0 with last: after counting, the block scans all 256 bins through
//     the single RAM read port, sets peak and background, and clears the
//     histogram. Input is held off after that transaction until the finish state.
//   cmd 1 (mapping): one result. The divider loads at acceptance, then runs a
//     prepare step, the quotient-bit steps and a hand-off into the output
//     register, whose valid drives pix_out_o. Input is held off until that
//     hand-off, which waits for a free output register, so no new pixel is
//     taken while a mapping is in the divider. A pixel below background, peak
//     not above background, or a quotient past 8 bits skips the quotient bits.
// A finished result sits in the output register; counting transactions and
// the next mapping transaction are still accepted while it waits. A further
// mapping result waits in the divider until the output register frees up.
// Reset: histogram reads as all zero at once (per-bin valid bits), peak and
// background are zero, so mapping before any scan gives 0. Ready is high.
module background_mode_contrast_stretch_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  bmcs_in_if.sink     pix_in_i,
  bmcs_out_if.source  pix_out_o
);

  bmcs_pkg::top_state_e state_q, state_d;

  logic                       in_acc, cnt_acc, map_acc;
  logic [bmcs_pkg::PIX_W-1:0] rd_addr;
  logic [bmcs_pkg::BIN_W-1:0] hist_rd;
  logic [bmcs_pkg::BIN_W-1:0] bin_cur, bin_inc;
  logic                       clr;

  // count pipeline stage
  logic                       s1_vld_q;
  logic [bmcs_pkg::PIX_W-1:0] s1_pix_q;
  logic                       fwd_hit_q, fwd_hit_d;
  logic [bmcs_pkg::BIN_W-1:0] fwd_data_q;

  // scan
  logic [bmcs_pkg::PIX_W-1:0] scan_cnt_q, scan_cnt_d;
  logic                       sc_rv_q;
  logic [bmcs_pkg::PIX_W-1:0] sc_idx_q;
  logic [bmcs_pkg::PIX_W-1:0] acc_top_q, acc_top_d;
  logic [bmcs_pkg::BIN_W-1:0] acc_cnt_q, acc_cnt_d;
  logic [bmcs_pkg::PIX_W-1:0] acc_val_q, acc_val_d;

  // statistics
  logic [bmcs_pkg::PIX_W-1:0] bg_q, bg_d;
  logic [bmcs_pkg::PIX_W-1:0] peak_q, peak_d;

  // output register and divider
  logic                       out_vld_q, out_vld_d;
  logic [bmcs_pkg::PIX_W-1:0] out_data_q, out_data_d;
  logic                       out_free;
  logic                       div_ack;
  bmcs_pkg::div_req_t         div_req;
  bmcs_pkg::div_rsp_t         div_rsp;

  // Handshake
  assign pix_in_i.ready = (state_q == bmcs_pkg::ST_RUN);
  assign in_acc  = pix_in_i.valid && pix_in_i.ready;
  assign cnt_acc = in_acc && (pix_in_i.cmd == bmcs_pkg::CMD_COUNT);
  assign map_acc = in_acc && (pix_in_i.cmd == bmcs_pkg::CMD_MAP);

  // Histogram RAM
  assign rd_addr = (state_q == bmcs_pkg::ST_SCAN) ? scan_cnt_q : pix_in_i.pixel;

  bmcs_hist u_hist (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_addr_i (rd_addr),
    .wr_en_i   (s1_vld_q),
    .wr_addr_i (s1_pix_q),
    .wr_data_i (bin_inc),
    .clr_i     (clr),
    .rd_data_o (hist_rd)
  );

  // Bin update with forwarding of the write that raced this read
  assign bin_cur   = fwd_hit_q ? fwd_data_q : hist_rd;
  assign bin_inc   = (bin_cur == bmcs_pkg::BIN_MAX) ? bin_cur : bin_cur + 17'd1;
  assign fwd_hit_d = s1_vld_q && (s1_pix_q == pix_in_i.pixel);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      fwd_hit_q <= 1'b0;
    end else begin
      s1_vld_q  <= cnt_acc;
      fwd_hit_q <= fwd_hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_pix_q   <= pix_in_i.pixel;
    fwd_data_q <= bin_inc;
  end

  // Scan accumulators: highest nonzero bin, first bin with the largest count
  always_comb begin
    acc_top_d = acc_top_q;
    acc_cnt_d = acc_cnt_q;
    acc_val_d = acc_val_q;
    if (state_q == bmcs_pkg::ST_WAIT) begin
      acc_top_d = '0;
      acc_cnt_d = '0;
      acc_val_d = '0;
    end else if (sc_rv_q) begin
      if (hist_rd != '0) begin
        acc_top_d = sc_idx_q;
      end
      if (hist_rd > acc_cnt_q) begin
        acc_cnt_d = hist_rd;
        acc_val_d = sc_idx_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_top_q <= acc_top_d;
    acc_cnt_q <= acc_cnt_d;
    acc_val_q <= acc_val_d;
    sc_idx_q  <= scan_cnt_q;
  end

  // Divider
  assign div_req.start = map_acc;
  assign div_req.pixel = pix_in_i.pixel;
  assign div_req.bg    = bg_q;
  assign div_req.peak  = peak_q;

  bmcs_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .ack_i  (div_ack),
    .rsp_o  (div_rsp)
  );

  assign out_free = !out_vld_q || pix_out_o.ready;

  // Sequencer
  always_comb begin
    state_d    = state_q;
    scan_cnt_d = scan_cnt_q;
    bg_d       = bg_q;
    peak_d     = peak_q;
    clr        = 1'b0;
    div_ack    = 1'b0;
    out_vld_d  = out_vld_q && !pix_out_o.ready;
    out_data_d = out_data_q;
    unique case (state_q)
      bmcs_pkg::ST_RUN: begin
        if (cnt_acc && pix_in_i.last) begin
          state_d = bmcs_pkg::ST_WAIT;
        end else if (map_acc) begin
          state_d = bmcs_pkg::ST_DIV;
        end
      end
      bmcs_pkg::ST_DIV: begin
        if (div_rsp.done && out_free) begin
          out_vld_d  = 1'b1;
          out_data_d = div_rsp.quot;
          div_ack    = 1'b1;
          state_d    = bmcs_pkg::ST_RUN;
        end
      end
      bmcs_pkg::ST_WAIT: begin
        // last bin write lands at the end of this cycle
        scan_cnt_d = '0;
        state_d    = bmcs_pkg::ST_SCAN;
      end
      bmcs_pkg::ST_SCAN: begin
        scan_cnt_d = scan_cnt_q + 8'd1;
        if (scan_cnt_q == 8'(bmcs_pkg::NUM_BINS - 1)) begin
          state_d = bmcs_pkg::ST_FIN;
        end
      end
      bmcs_pkg::ST_FIN: begin
        bg_d    = acc_val_d;
        peak_d  = acc_top_d;
        clr     = 1'b1;
        state_d = bmcs_pkg::ST_RUN;
      end
      default: state_d = bmcs_pkg::ST_RUN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= bmcs_pkg::ST_RUN;
      scan_cnt_q <= '0;
      sc_rv_q    <= 1'b0;
      bg_q       <= '0;
      peak_q     <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      scan_cnt_q <= scan_cnt_d;
      sc_rv_q    <= (state_q == bmcs_pkg::ST_SCAN);
      bg_q       <= bg_d;
      peak_q     <= peak_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign pix_out_o.valid     = out_vld_q;
  assign pix_out_o.stretched = out_data_q;

  // Checks
  a_no_write_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bmcs_pkg::ST_SCAN || state_q == bmcs_pkg::ST_FIN) |-> !s1_vld_q)
    else $error("bin write pending during scan");

  a_bg_not_above_peak: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bg_q <= peak_q)
    else $error("background above peak");

  a_map_enters_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    map_acc |=> (state_q == bmcs_pkg::ST_DIV))
    else $error("mapping transaction did not start divider");

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == bmcs_pkg::ST_DIV))
    else $error("divider result outside divide state");

endmodule

FILE: test/background_mode_contrast_stretch_top_tb.sv
// Testbench for background_mode_contrast_stretch_top: histogram counting passes,
// background/peak scan and stretched mapping, checked against an in-bench predictor.
// Depends on bmcs_pkg, bmcs_in_if and bmcs_out_if.
`timescale 1ns / 1ps

module background_mode_contrast_stretch_top_tb;

  localparam int unsigned CYCLE_LIMIT = 1_500_000;
  localparam int unsigned HOLD_CYCLES = 700;
  localparam int unsigned RAND_ITEMS  = 1050;
  // Equal counts on two bins
  localparam int unsigned TIE_COUNT   = 3;

  // Tracks histogram and levels, holds the stretched values still owed by the block
  class stretch_tracker;
    bit [bmcs_pkg::BIN_W-1:0] bin_cnt [bmcs_pkg::NUM_BINS];
    bit [bmcs_pkg::PIX_W-1:0] bg_lvl;
    bit [bmcs_pkg::PIX_W-1:0] peak_lvl;
    bit [bmcs_pkg::PIX_W-1:0] pending_levels [$];
    int unsigned              mismatches;

    function new();
      foreach (bin_cnt[v]) bin_cnt[v] = '0;
      bg_lvl     = '0;
      peak_lvl   = '0;
      mismatches = 0;
    endfunction

    // Expected stretched value under the current levels
    function bit [bmcs_pkg::PIX_W-1:0] stretch_of(bit [bmcs_pkg::PIX_W-1:0] pix);
      int unsigned num;
      int unsigned den;
      int unsigned quo;
      if (pix < bg_lvl || peak_lvl <= bg_lvl) return '0;
      num = (32'(pix) - 32'(bg_lvl)) * 32'(bmcs_pkg::FULL_SCALE);
      den = 32'(peak_lvl) - 32'(bg_lvl);
      quo = num / den;
      return (quo > 32'(bmcs_pkg::FULL_SCALE)) ? bmcs_pkg::FULL_SCALE
                                               : quo[bmcs_pkg::PIX_W-1:0];
    endfunction

    // Called on every accepted input transaction
    function void take_pixel(bit cmd, bit [bmcs_pkg::PIX_W-1:0] pix, bit last);
      int unsigned best_cnt;
      int unsigned best_val;
      int unsigned top;
      if (cmd == bmcs_pkg::CMD_MAP) begin
        pending_levels.push_back(stretch_of(pix));
        return;
      end
      if (bin_cnt[pix] != bmcs_pkg::BIN_MAX) bin_cnt[pix]++;
      if (!last) return;
      // Scan: highest occupied bin is the peak, most frequent (lowest on tie) the background
      best_cnt = 0;
      best_val = 0;
      top      = 0;
      for (int unsigned v = 0; v < bmcs_pkg::NUM_BINS; v++) begin
        if (bin_cnt[v] != '0) top = v;
        if (32'(bin_cnt[v]) > best_cnt) begin
          best_cnt = 32'(bin_cnt[v]);
          best_val = v;
        end
        bin_cnt[v] = '0;
      end
      peak_lvl = top[bmcs_pkg::PIX_W-1:0];
      bg_lvl   = best_val[bmcs_pkg::PIX_W-1:0];
    endfunction

    // Called on every accepted output transaction
    function void match_output(bit [bmcs_pkg::PIX_W-1:0] got);
      bit [bmcs_pkg::PIX_W-1:0] want;
      if (pending_levels.size() == 0) begin
        $error("stretched: unexpected result %0d with nothing pending", got);
        mismatches++;
        return;
      end
      want = pending_levels.pop_front();
      if (got !== want) begin
        $error("stretched: expected %0d, actual %0d", want, got);
        mismatches++;
      end
    endfunction

    function int pending_count();
      return pending_levels.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  bmcs_in_if  pix_in ();
  bmcs_out_if pix_out ();

  background_mode_contrast_stretch_top i_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .pix_in_i  (pix_in),
    .pix_out_o (pix_out)
  );

  stretch_tracker tracker;

  int unsigned cycles;
  int unsigned items_sent;
  int unsigned burst_left;
  int unsigned hold_asks;
  int unsigned hold_seen;
  int unsigned hold_left;
  int unsigned rx_mode;
  int unsigned rx_mode_left;
  int unsigned rx_tick;

  // Clock
  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("background_mode_contrast_stretch_top regression: fail");
      $finish;
    end
  end

  // Output monitor: sample accepted results at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && pix_out.valid && pix_out.ready) tracker.match_output(pix_out.stretched);
  end

  // Receiver: its own stall pattern, plus long hold-offs on request
  always @(negedge clk_i) begin
    if (rst_ni) begin
      rx_tick++;
      if (hold_asks != hold_seen) begin
        hold_seen = hold_asks;
        hold_left = HOLD_CYCLES;
      end
      if (rx_mode_left == 0) begin
        rx_mode      = $urandom_range(0, 3);
        rx_mode_left = $urandom_range(20, 300);
      end else begin
        rx_mode_left--;
      end
      if (hold_left != 0) begin
        hold_left--;
        pix_out.ready <= 1'b0;
      end else begin
        case (rx_mode)
          0: pix_out.ready <= 1'b1;
          1: pix_out.ready <= 1'($urandom_range(0, 1));
          2: pix_out.ready <= ($urandom_range(0, 9) < 8);
          default: pix_out.ready <= ((rx_tick % 7) < 3);
        endcase
      end
    end
  end

  // Offer one transaction and wait for it to be taken; returns at a falling edge
  task automatic send_item(input bit cmd, input bit [bmcs_pkg::PIX_W-1:0] pix,
                           input bit last);
    pix_in.valid <= 1'b1;
    pix_in.cmd   <= cmd;
    pix_in.pixel <= pix;
    pix_in.last  <= last;
    @(posedge clk_i);
    while (!pix_in.ready) @(posedge clk_i);
    tracker.take_pixel(cmd, pix, last);
    items_sent++;
    @(negedge clk_i);
  endtask

  // Sender pacing: bursts of random length, random gaps in between
  task automatic pace();
    int unsigned gap;
    if (burst_left != 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 250) : $urandom_range(0, 30);
      gap = $urandom_range(1, 12);
      pix_in.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  task automatic send_paced(input bit cmd, input bit [bmcs_pkg::PIX_W-1:0] pix,
                            input bit last);
    send_item(cmd, pix, last);
    pace();
  endtask

  // Stop offering until every owed result has come back
  task automatic drain();
    pix_in.valid <= 1'b0;
    @(negedge clk_i);
    while (tracker.pending_count() != 0) @(negedge clk_i);
  endtask

  initial begin
    int unsigned pass_cnt;
    int unsigned kind;
    int unsigned len;
    int          center;
    int          spread;
    int          val;

    tracker       = new();
    cycles        = 0;
    items_sent    = 0;
    burst_left    = 0;
    hold_asks     = 0;
    hold_seen     = 0;
    hold_left     = 0;
    rx_mode       = 0;
    rx_mode_left  = 0;
    rx_tick       = 0;
    rst_ni        = 1'b0;
    pix_in.valid  = 1'b0;
    pix_in.cmd    = bmcs_pkg::CMD_COUNT;
    pix_in.pixel  = '0;
    pix_in.last   = 1'b0;
    pix_out.ready = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Mapping before any scan: reset levels give 0, last flag ignored
    send_paced(bmcs_pkg::CMD_MAP, 8'd0, 1'b0);
    send_paced(bmcs_pkg::CMD_MAP, 8'd255, 1'b0);
    send_paced(bmcs_pkg::CMD_MAP, 8'd128, 1'b1);

    // Background 85, peak 255: below, at, inside and top of range
    send_paced(bmcs_pkg::CMD_COUNT, 8'd0, 1'b0);
    send_paced(bmcs_pkg::CMD_COUNT, 8'd255, 1'b0);
    send_paced(bmcs_pkg::CMD_COUNT, 8'd170, 1'b0);
    send_paced(bmcs_pkg::CMD_COUNT, 8'd85, 1'b0);
    send_paced(bmcs_pkg::CMD_COUNT, 8'd85, 1'b1);
    send_paced(bmcs_pkg::CMD_MAP, 8'd0, 1'b0);
    send_paced(bmcs_pkg::CMD_MAP, 8'd84, 1'b0);
    send_paced(bmcs_pkg::CMD_MAP, 8'd85, 1'b0);
    send_paced(bmcs_pkg::CMD_MAP, 8'd255, 1'b0);
    send_paced(bmcs_pkg::CMD_MAP, 8'd170, 1'b1);

    // Single-value pass: peak equals background
    send_paced(bmcs_pkg::CMD_COUNT, 8'd200, 1'b1);
    send_paced(bmcs_pkg::CMD_MAP, 8'd200, 1'b0);
    send_paced(bmcs_pkg::CMD_MAP, 8'd255, 1'b0);
    send_paced(bmcs_pkg::CMD_MAP, 8'd10, 1'b0);

    // Pixels above the peak saturate at full scale
    send_paced(bmcs_pkg::CMD_COUNT, 8'd10, 1'b0);
    send_paced(bmcs_pkg::CMD_COUNT, 8'd10, 1'b0);
    send_paced(bmcs_pkg::CMD_COUNT, 8'd20, 1'b1);
    send_paced(bmcs_pkg::CMD_MAP, 8'd21, 1'b0);
    send_paced(bmcs_pkg::CMD_MAP, 8'd255, 1'b0);
    send_paced(bmcs_pkg::CMD_MAP, 8'd15, 1'b0);

    // Two bins tie on count: the lower value wins background
    for (int unsigned i = 0; i < TIE_COUNT; i++) begin
      send_item(bmcs_pkg::CMD_COUNT, 8'd200, 1'b0);
      send_item(bmcs_pkg::CMD_COUNT, 8'd100, 1'b0);
    end
    send_paced(bmcs_pkg::CMD_COUNT, 8'd50, 1'b1);
    send_paced(bmcs_pkg::CMD_MAP, 8'd99, 1'b0);
    send_paced(bmcs_pkg::CMD_MAP, 8'd100, 1'b0);
    send_paced(bmcs_pkg::CMD_MAP, 8'd150, 1'b0);
    send_paced(bmcs_pkg::CMD_MAP, 8'd200, 1'b0);
    send_paced(bmcs_pkg::CMD_MAP, 8'd201, 1'b0);
    drain();

    // Random passes: mostly count-then-map, some noise and unterminated passes
    pass_cnt = 0;
    while (items_sent < RAND_ITEMS) begin
      pass_cnt++;
      kind = $urandom_range(0, 9);
      if (kind < 8) begin
        len    = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 300) : $urandom_range(1, 40);
        center = int'($urandom_range(0, 255));
        spread = ($urandom_range(0, 3) == 0) ? 255 : int'($urandom_range(0, 20));
        for (int unsigned i = 0; i < len; i++) begin
          val = center + int'($urandom_range(0, 2 * spread)) - spread;
          if (val < 0) val = 0;
          if (val > 255) val = 255;
          send_paced(bmcs_pkg::CMD_COUNT, val[bmcs_pkg::PIX_W-1:0], i == len - 1);
        end
      end else if (kind == 8) begin
        len = $urandom_range(1, 20);
        for (int unsigned i = 0; i < len; i++) begin
          send_paced(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                     $urandom_range(0, 3) == 0);
        end
      end else begin
        // Counting without a closing pixel: old levels stay, bins carry over
        len = $urandom_range(1, 15);
        for (int unsigned i = 0; i < len; i++) begin
          send_paced(bmcs_pkg::CMD_COUNT, 8'($urandom_range(0, 255)), 1'b0);
        end
      end

      // Receiver holds off while mapping transactions keep coming
      if (pass_cnt == 4 || pass_cnt == 25) begin
        hold_asks++;
        for (int unsigned i = 0; i < 20; i++) begin
          send_item(bmcs_pkg::CMD_MAP, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end
      end

      len = $urandom_range(1, 25);
      for (int unsigned i = 0; i < len; i++) begin
        send_paced(bmcs_pkg::CMD_MAP, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end

      if (pass_cnt % 10 == 0) drain();
    end

    // Wrap-up: all results in, then idle past the scan latency
    drain();
    repeat (400) @(negedge clk_i);
    if (tracker.pending_count() != 0) begin
      $error("stretched: %0d expected results never arrived", tracker.pending_count());
      tracker.mismatches++;
    end
    if (tracker.mismatches == 0) begin
      $display("background_mode_contrast_stretch_top regression: pass");
    end else begin
      $display("background_mode_contrast_stretch_top regression: fail");
    end
    $finish;
  end

endmodule
